// ----- hdl/tpc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants of the tftp payload classifier
// opcode values, packet kinds, verdict record and queue sizing
// ----------------------------------------------------------------------------
package tpc_pkg;

  // big-endian opcodes in the first two payload bytes
  localparam logic [15:0] OP_RRQ   = 16'd1;
  localparam logic [15:0] OP_WRQ   = 16'd2;
  localparam logic [15:0] OP_DATA  = 16'd3;
  localparam logic [15:0] OP_ACK   = 16'd4;
  localparam logic [15:0] OP_ERROR = 16'd5;

  // packet kind reported with the verdict
  localparam logic [2:0] KIND_NONE = 3'd0;

  // largest accepted error code, and the only accepted data or ack block
  localparam logic [15:0] MAX_ERROR_CODE = 16'd8;
  localparam logic [15:0] FIRST_BLOCK    = 16'd1;

  // default depth of the verdict queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       is_tftp;
    logic [2:0] kind;
  } verdict_t;

endpackage
`default_nettype wire

// ----- hdl/tpc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_front: per-byte classifier
// tracks position, opcode, field word and the request pattern automaton;
// emits one verdict on the last byte of a packet
// ----------------------------------------------------------------------------
module tpc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        payload_byte,
  input  wire logic              last_byte,
  output logic                   verdict_push,
  output tpc_pkg::verdict_t      verdict
);

  typedef enum logic [4:0] {
    ST_START      = 5'd0,
    ST_OPBYTE     = 5'd1,
    ST_NAME_FIRST = 5'd2,
    ST_NAME_MORE  = 5'd3,
    ST_MODE_FIRST = 5'd4,
    ST_NA_N       = 5'd5,
    ST_NA_E       = 5'd6,
    ST_NA_T       = 5'd7,
    ST_NA_A       = 5'd8,
    ST_NA_S       = 5'd9,
    ST_NA_C       = 5'd10,
    ST_NA_I1      = 5'd11,
    ST_NA_I2      = 5'd12,
    ST_OC_O       = 5'd13,
    ST_OC_C       = 5'd14,
    ST_OC_T       = 5'd15,
    ST_OC_E       = 5'd16,
    ST_OC_T2      = 5'd17,
    ST_MA_M       = 5'd18,
    ST_MA_A       = 5'd19,
    ST_MA_I       = 5'd20,
    ST_MA_L       = 5'd21
  } pat_state_t;

  logic [2:0]  pos;
  logic [2:0]  pos_next;
  logic [15:0] opcode_word;
  logic [15:0] opcode_next;
  logic [15:0] field_word;
  logic [15:0] field_next;
  pat_state_t  pat_state;
  pat_state_t  pat_state_next;
  logic        pat_done;
  logic        pat_done_next;
  logic        pat_failed;
  logic        pat_failed_next;

  logic [7:0]  lower_byte;
  logic        is_name_char;
  logic        letter_step;
  logic        letter_term;
  logic [7:0]  letter_expect;
  logic        ok;

  always_comb begin
    lower_byte = (payload_byte inside {["A":"Z"]}) ? payload_byte + 8'd32 : payload_byte;
    is_name_char = (payload_byte inside {"-", ".", " ", ["a":"z"], ["A":"Z"], ["1":"9"]});
  end

  // field capture and position
  always_comb begin
    opcode_next = opcode_word;
    field_next  = field_word;
    case (pos)
      3'd0:    opcode_next[15:8] = payload_byte;
      3'd1:    opcode_next[7:0]  = payload_byte;
      3'd2:    field_next[15:8]  = payload_byte;
      3'd3:    field_next[7:0]   = payload_byte;
      default: ;
    endcase
    pos_next = (pos == 3'd7) ? pos : pos + 3'd1;
  end

  // request pattern automaton
  always_comb begin
    pat_state_next  = pat_state;
    pat_done_next   = pat_done;
    pat_failed_next = pat_failed;
    letter_step     = 1'b0;
    letter_term     = 1'b0;
    letter_expect   = 8'h00;
    case (pat_state)
      ST_NA_N:  begin letter_step = 1'b1; letter_expect = "e"; end
      ST_NA_E:  begin letter_step = 1'b1; letter_expect = "t"; end
      ST_NA_T:  begin letter_step = 1'b1; letter_expect = "a"; end
      ST_NA_A:  begin letter_step = 1'b1; letter_expect = "s"; end
      ST_NA_S:  begin letter_step = 1'b1; letter_expect = "c"; end
      ST_NA_C:  begin letter_step = 1'b1; letter_expect = "i"; end
      ST_NA_I1: begin letter_step = 1'b1; letter_expect = "i"; end
      ST_NA_I2: begin letter_step = 1'b1; letter_term = 1'b1; end
      ST_OC_O:  begin letter_step = 1'b1; letter_expect = "c"; end
      ST_OC_C:  begin letter_step = 1'b1; letter_expect = "t"; end
      ST_OC_T:  begin letter_step = 1'b1; letter_expect = "e"; end
      ST_OC_E:  begin letter_step = 1'b1; letter_expect = "t"; end
      ST_OC_T2: begin letter_step = 1'b1; letter_term = 1'b1; end
      ST_MA_M:  begin letter_step = 1'b1; letter_expect = "a"; end
      ST_MA_A:  begin letter_step = 1'b1; letter_expect = "i"; end
      ST_MA_I:  begin letter_step = 1'b1; letter_expect = "l"; end
      ST_MA_L:  begin letter_step = 1'b1; letter_term = 1'b1; end
      default:  ;
    endcase

    if (!pat_done && !pat_failed) begin
      case (pat_state)
        ST_START: begin
          if (payload_byte == 8'h00) pat_state_next = ST_OPBYTE;
          else pat_failed_next = 1'b1;
        end
        ST_OPBYTE: begin
          if (payload_byte inside {8'h01, 8'h02, 8'h7c}) pat_state_next = ST_NAME_FIRST;
          else pat_failed_next = 1'b1;
        end
        ST_NAME_FIRST: begin
          if (is_name_char) pat_state_next = ST_NAME_MORE;
          else pat_failed_next = 1'b1;
        end
        ST_NAME_MORE: begin
          if (is_name_char) pat_state_next = ST_NAME_MORE;
          else if (payload_byte == 8'h00) pat_state_next = ST_MODE_FIRST;
          else pat_failed_next = 1'b1;
        end
        ST_MODE_FIRST: begin
          if (lower_byte == "n") pat_state_next = ST_NA_N;
          else if (lower_byte == "o") pat_state_next = ST_OC_O;
          else if (lower_byte == "m") pat_state_next = ST_MA_M;
          else pat_failed_next = 1'b1;
        end
        default: begin
          if (!letter_step) pat_failed_next = 1'b1;
          else if (letter_term) begin
            if (payload_byte == 8'h00) pat_done_next = 1'b1;
            else pat_failed_next = 1'b1;
          end else if (lower_byte == letter_expect) begin
            pat_state_next = pat_state_t'(pat_state + 5'd1);
          end else begin
            pat_failed_next = 1'b1;
          end
        end
      endcase
    end
  end

  // verdict on the last byte, from the updated state
  always_comb begin
    ok = 1'b0;
    if (pos >= 3'd2) begin
      case (opcode_next)
        tpc_pkg::OP_RRQ, tpc_pkg::OP_WRQ:  ok = pat_done_next;
        tpc_pkg::OP_DATA, tpc_pkg::OP_ACK: ok = (pos >= 3'd3) &&
                                                (field_next == tpc_pkg::FIRST_BLOCK);
        tpc_pkg::OP_ERROR:                 ok = (pos >= 3'd3) &&
                                                (field_next <= tpc_pkg::MAX_ERROR_CODE);
        default:                           ok = 1'b0;
      endcase
    end
    verdict_push    = accept && last_byte;
    verdict.is_tftp = ok;
    verdict.kind    = ok ? opcode_next[2:0] : tpc_pkg::KIND_NONE;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      pos         <= 3'd0;
      opcode_word <= 16'd0;
      field_word  <= 16'd0;
      pat_state   <= ST_START;
      pat_done    <= 1'b0;
      pat_failed  <= 1'b0;
    end else if (accept) begin
      pos         <= pos_next;
      opcode_word <= opcode_next;
      field_word  <= field_next;
      pat_state   <= pat_state_next;
      pat_done    <= pat_done_next;
      pat_failed  <= pat_failed_next;
    end
  end

  // a new packet always starts from the beginning
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && last_byte) |=> (pos == 3'd0 && pat_state == ST_START))
    else $error("packet state not cleared after last byte");

  // a kind is reported only with a positive verdict
  a_kind: assert property (@(posedge clk) disable iff (rst)
    verdict_push |-> (verdict.is_tftp == (verdict.kind != tpc_pkg::KIND_NONE)))
    else $error("packet kind disagrees with verdict");

  // the automaton never ends up both matched and failed
  a_pat: assert property (@(posedge clk) disable iff (rst)
    !(pat_done && pat_failed))
    else $error("pattern both done and failed");

endmodule
`default_nettype wire

// ----- hdl/tpc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_queue: verdict queue
// small register fifo between the classifier front and the result stage
// ----------------------------------------------------------------------------
module tpc_queue #(
  parameter int DEPTH = tpc_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire tpc_pkg::verdict_t wr_data,
  output logic                   full,
  input  wire logic              rd_en,
  output tpc_pkg::verdict_t      rd_data,
  output logic                   not_empty
);

  localparam int AW = $clog2(DEPTH);

  tpc_pkg::verdict_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) count <= count + (AW+1)'(1);
      else if (!wr_en && rd_en) count <= count - (AW+1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && full))
    else $error("verdict queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> not_empty)
    else $error("verdict queue read while empty");

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("verdict queue count out of range");

endmodule
`default_nettype wire

// ----- hdl/tpc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpc_back: result stage
// pulls verdicts from the queue into an output register for the consumer
// ----------------------------------------------------------------------------
module tpc_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  input  wire tpc_pkg::verdict_t q_data,
  output logic                   q_rd,
  output logic                   empty,
  input  wire logic              pop,
  output logic                   is_tftp,
  output logic [2:0]             packet_kind
);

  logic              held;
  tpc_pkg::verdict_t result;

  // refill whenever the register is free or being drained
  assign q_rd        = q_valid && (!held || pop);
  assign empty       = !held;
  assign is_tftp     = result.is_tftp;
  assign packet_kind = result.kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (q_rd) begin
      held <= 1'b1;
    end else if (pop) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      result <= q_data;
    end
  end

  // a waiting verdict is not dropped before it is popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (held && !pop) |=> (held && $stable(result)))
    else $error("result changed before it was taken");

endmodule
`default_nettype wire

// ----- hdl/tftp_payload_classifier_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tftp_payload_classifier_top: tftp payload classifier
// byte-serial classifier giving one tftp verdict per packet
// ----------------------------------------------------------------------------
// Payload bytes are pushed one per item, in order, with last_byte marking the
// final byte of a packet. Only the last byte produces a result: is_tftp and
// packet_kind (0 none, 1 rrq, 2 wrq, 3 data, 4 ack, 5 error). A packet is tftp
// when it has at least three bytes, its big-endian opcode is 1 to 5, and the
// per-opcode test holds: requests must match 0x00, opcode byte, filename,
// 0x00, netascii/octet/mail in any case, 0x00 (later bytes ignored); data and
// ack need block number 1; error needs a code of at most 8. The block takes
// one byte every clock cycle while full is low: the classifier front updates
// its small automaton for each byte and never stalls on its own. A verdict is
// written into the verdict queue at the edge that accepts its last byte and
// is loaded from there into the output register once that register is free
// or being popped. full rises only when the verdict queue (QUEUE_DEPTH
// entries) and the output register are both occupied because the consumer
// is not popping; bytes that are not last still need a queue slot free to
// be accepted.
// ----------------------------------------------------------------------------
module tftp_payload_classifier_top #(
  parameter int QUEUE_DEPTH = tpc_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // byte input, queue style
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] payload_byte,
  input  wire logic       last_byte,
  // verdict output, queue style
  output logic            empty,
  input  wire logic       pop,
  output logic            is_tftp,
  output logic [2:0]      packet_kind
);

  logic              accept;
  logic              verdict_push;
  tpc_pkg::verdict_t verdict;
  logic              q_full;
  logic              q_not_empty;
  logic              q_rd;
  tpc_pkg::verdict_t q_data;

  // an item is taken whenever the verdict queue has room
  assign full   = q_full;
  assign accept = push && !q_full;

  // front: position, opcode, field word and request pattern per byte
  tpc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .payload_byte (payload_byte),
    .last_byte    (last_byte),
    .verdict_push (verdict_push),
    .verdict      (verdict)
  );

  // decouples the front from a stalled consumer
  tpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (verdict_push),
    .wr_data   (verdict),
    .full      (q_full),
    .rd_en     (q_rd),
    .rd_data   (q_data),
    .not_empty (q_not_empty)
  );

  // back: output register presenting the oldest verdict
  tpc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_not_empty),
    .q_data      (q_data),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .is_tftp     (is_tftp),
    .packet_kind (packet_kind)
  );

endmodule
`default_nettype wire
